// ----- src/swrm_pkg.sv -----
package swrm_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 11;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_MAX  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_FILL = 1'b1
  } state_t;

endpackage

// ----- src/swrm_ram.sv -----
module swrm_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [swrm_pkg::DATA_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [swrm_pkg::DATA_W-1:0] rdata
);

  logic [swrm_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/stack_with_running_max_top.sv -----
// Stack with running maximum: value stack and companion max stack in two RAMs.
// Push, peek and max finish as the word is accepted; pop then enters a refill
// state that loads the top registers from the registered RAM read port, and no
// new word is accepted until it is done. The result is registered on acceptance.
// Synchronous active-low reset empties both stacks and sets capacity to 1024;
// RAM contents are not cleared.
module stack_with_running_max_top #(
  parameter int DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] cmd, [33:2] push_value, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] data, [33:32] status, [44:34] depth_now
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = CW + swrm_pkg::CAP_W;
  localparam int DW = swrm_pkg::DATA_W;

  swrm_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]         vcnt_r, vcnt_nxt;
  logic [CW-1:0]         mcnt_r, mcnt_nxt;
  logic signed [DW-1:0]  vtop_r, vtop_nxt;
  logic signed [DW-1:0]  mtop_r, mtop_nxt;
  logic                  mpop_r, mpop_nxt;
  logic [swrm_pkg::CAP_W-1:0] cap_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [DW-1:0]         out_data_r, out_data_nxt;
  swrm_pkg::status_t     out_stat_r, out_stat_nxt;
  logic [swrm_pkg::CAP_W-1:0] out_depth_r, out_depth_nxt;

  logic                  v_we, m_we, rd_en;
  logic [AW-1:0]         v_waddr, m_waddr, v_raddr, m_raddr;
  logic [DW-1:0]         v_rdata, m_rdata;
  logic [DW-1:0]         wdata;

  logic                  acc;
  swrm_pkg::cmd_t        cmd;
  logic signed [DW-1:0]  pv;
  logic [WW-1:0]         cnt_w, cap_w, lim_w;
  logic [WW-1:0]         vcnt_nxt_w;

  assign cmd   = swrm_pkg::cmd_t'(in_tdata[1:0]);
  assign pv    = in_tdata[33:2];
  assign wdata = pv;

  assign in_tready = (state_r == swrm_pkg::S_IDLE) && (!out_valid_r || out_tready);
  assign acc       = in_tvalid && in_tready;

  assign cnt_w = WW'(vcnt_r);
  assign cap_w = WW'(cap_r);
  assign lim_w = (cap_w > WW'(DEPTH)) ? WW'(DEPTH) : cap_w;
  assign vcnt_nxt_w = WW'(vcnt_nxt);

  always_comb begin
    state_nxt     = state_r;
    vcnt_nxt      = vcnt_r;
    mcnt_nxt      = mcnt_r;
    vtop_nxt      = vtop_r;
    mtop_nxt      = mtop_r;
    mpop_nxt      = mpop_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    out_depth_nxt = out_depth_r;
    v_we          = 1'b0;
    m_we          = 1'b0;
    rd_en         = 1'b0;
    v_waddr       = vcnt_r[AW-1:0];
    m_waddr       = mcnt_r[AW-1:0];
    // entry below the current top
    v_raddr       = AW'(vcnt_r - CW'(2));
    m_raddr       = AW'(mcnt_r - CW'(2));

    unique case (state_r)
      swrm_pkg::S_FILL: begin
        vtop_nxt  = v_rdata;
        if (mpop_r) begin
          mtop_nxt = m_rdata;
        end
        state_nxt = swrm_pkg::S_IDLE;
      end
      default: begin
        if (acc) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_stat_nxt  = swrm_pkg::ST_OK;
          unique case (cmd)
            swrm_pkg::CMD_PUSH: begin
              if (cnt_w >= lim_w) begin
                out_stat_nxt = swrm_pkg::ST_FULL;
              end else begin
                v_we     = 1'b1;
                vtop_nxt = pv;
                vcnt_nxt = vcnt_r + CW'(1);
                if (vcnt_r == '0 || mcnt_r == '0 || pv >= mtop_r) begin
                  m_we     = 1'b1;
                  mtop_nxt = pv;
                  mcnt_nxt = mcnt_r + CW'(1);
                end
              end
            end
            swrm_pkg::CMD_POP: begin
              if (vcnt_r == '0) begin
                out_stat_nxt = swrm_pkg::ST_EMPTY;
              end else begin
                out_data_nxt = vtop_r;
                vcnt_nxt     = vcnt_r - CW'(1);
                mpop_nxt     = (mcnt_r != '0) && (mtop_r == vtop_r);
                if (mpop_nxt) begin
                  mcnt_nxt = mcnt_r - CW'(1);
                end
                rd_en     = 1'b1;
                state_nxt = swrm_pkg::S_FILL;
              end
            end
            swrm_pkg::CMD_PEEK: begin
              if (vcnt_r == '0) begin
                out_stat_nxt = swrm_pkg::ST_EMPTY;
              end else begin
                out_data_nxt = vtop_r;
              end
            end
            swrm_pkg::CMD_MAX: begin
              if (mcnt_r == '0) begin
                out_stat_nxt = swrm_pkg::ST_EMPTY;
              end else begin
                out_data_nxt = mtop_r;
              end
            end
          endcase
          out_depth_nxt = vcnt_nxt_w[swrm_pkg::CAP_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swrm_pkg::S_IDLE;
      vcnt_r      <= '0;
      mcnt_r      <= '0;
      mpop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= swrm_pkg::CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      vcnt_r      <= vcnt_nxt;
      mcnt_r      <= mcnt_nxt;
      mpop_r      <= mpop_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    vtop_r      <= vtop_nxt;
    mtop_r      <= mtop_nxt;
    out_data_r  <= out_data_nxt;
    out_stat_r  <= out_stat_nxt;
    out_depth_r <= out_depth_nxt;
  end

  swrm_ram #(.DEPTH(DEPTH), .AW(AW)) u_val_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  swrm_ram #(.DEPTH(DEPTH), .AW(AW)) u_max_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_depth_r, out_stat_r, out_data_r};

endmodule

// ----- tb/max_stack_checker.sv -----
`timescale 1ns / 100ps

module max_stack_checker
  import swrm_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] cmd, [33:2] push_value, rest zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // [31:0] data, [33:32] status, [44:34] depth_now
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  output int          n_fail,
  output int          n_pending
);

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_t                  status;
    logic [CAP_W-1:0]         depth;
  } stack_reply_t;

  // shadow copy of both stacks and the capacity register
  logic signed [DATA_W-1:0] val_stk [DEPTH];
  logic signed [DATA_W-1:0] max_stk [DEPTH];
  int                       val_cnt;
  int                       max_cnt;
  logic [CAP_W-1:0]         capacity;

  stack_reply_t replies_due [$];
  stack_reply_t want;
  int           fails;

  logic signed [DATA_W-1:0] got_data;
  logic [STAT_W-1:0]        got_status;
  logic [CAP_W-1:0]         got_depth;

  function automatic stack_reply_t stack_op(cmd_t op, logic signed [DATA_W-1:0] v);
    stack_reply_t r;
    int           lim;
    r.data   = '0;
    r.status = ST_OK;
    lim = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
    case (op)
      CMD_PUSH: begin
        if (val_cnt >= lim) begin
          r.status = ST_FULL;
        end else begin
          if (val_cnt == 0 || max_cnt == 0 ||
              (max_cnt < DEPTH && v >= max_stk[max_cnt-1])) begin
            max_stk[max_cnt] = v;
            max_cnt++;
          end
          val_stk[val_cnt] = v;
          val_cnt++;
        end
      end
      CMD_POP: begin
        if (val_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          val_cnt--;
          r.data = val_stk[val_cnt];
          // companion follows only when the popped word is the current max
          if (max_cnt > 0 && max_stk[max_cnt-1] == r.data) max_cnt--;
        end
      end
      CMD_PEEK: begin
        if (val_cnt == 0) r.status = ST_EMPTY;
        else r.data = val_stk[val_cnt-1];
      end
      default: begin
        if (max_cnt == 0) r.status = ST_EMPTY;
        else r.data = max_stk[max_cnt-1];
      end
    endcase
    r.depth = val_cnt[CAP_W-1:0];
    return r;
  endfunction

  initial begin
    fails   = 0;
    val_cnt = 0;
    max_cnt = 0;
    capacity = CAP_RESET;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      val_cnt  = 0;
      max_cnt  = 0;
      capacity = CAP_RESET;
      replies_due.delete();
    end else begin
      if (cfg_wr_en) capacity = cfg_wr_data;
      if (in_tvalid && in_tready)
        replies_due.push_back(stack_op(cmd_t'(in_tdata[1:0]), in_tdata[33:2]));
      if (out_tvalid && out_tready) begin
        got_data   = out_tdata[31:0];
        got_status = out_tdata[33:32];
        got_depth  = out_tdata[44:34];
        if (replies_due.size() == 0) begin
          $error("result word with nothing outstanding: data %0d status %0d depth %0d",
                 got_data, got_status, got_depth);
          fails++;
        end else begin
          want = replies_due.pop_front();
          if (got_data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, got_data);
            fails++;
          end
          if (got_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            fails++;
          end
          if (got_depth !== want.depth) begin
            $error("depth_now: expected %0d, got %0d", want.depth, got_depth);
            fails++;
          end
        end
      end
    end
    n_fail    <= fails;
    n_pending <= replies_due.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import swrm_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int CYCLE_LIMIT = 500000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;     // [1:0] cmd, [33:2] push_value, rest zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // [31:0] data, [33:32] status, [44:34] depth_now
  logic        cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = '0;

  int n_fail;
  int n_pending;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold_len = 0;

  stack_with_running_max_top #(.DEPTH(DEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  max_stack_checker #(.DEPTH(DEPTH)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .n_fail     (n_fail),
    .n_pending  (n_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("stack_with_running_max_top: mismatch");
    $finish;
  end

  // result side: random stalls, plus a long hold-off when requested
  initial begin : sink
    int stall;
    @(posedge clk);
    forever begin
      if (rx_hold_len > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
      end
      stall = rx_idle ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($urandom_range(0, 6)) - 32'd3;  // small, many repeats
      default: return $urandom;
    endcase
  endfunction

  task automatic send(cmd_t op, logic [31:0] v);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {6'b0, v, op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering words and wait for every result to come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [10:0] c);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_mix(int n, int push_pct);
    int   k;
    cmd_t op;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < push_pct) op = CMD_PUSH;
      else op = cmd_t'($urandom_range(1, 3));
      send(op, pick_value());
    end
  endtask

  initial begin : stim
    int k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty stack, extremes, ties with the current max
    send(CMD_POP, 32'hFFFF_FFFF);
    send(CMD_PEEK, 32'h0);
    send(CMD_MAX, 32'h0);
    send(CMD_PUSH, 32'h8000_0000);
    send(CMD_PUSH, 32'h7FFF_FFFF);
    send(CMD_PUSH, 32'h7FFF_FFFF);
    send(CMD_PUSH, 32'hFFFF_FFFF);
    send(CMD_PEEK, 32'h0);
    send(CMD_MAX, 32'h0);
    send(CMD_POP, 32'h0);
    send(CMD_POP, 32'h0);
    send(CMD_MAX, 32'h0);
    send(CMD_POP, 32'h0);
    send(CMD_MAX, 32'h0);
    send(CMD_POP, 32'h0);

    set_capacity(11'd1);
    send(CMD_PUSH, 32'd5);
    send(CMD_PUSH, 32'd6);
    send(CMD_POP, 32'h0);
    set_capacity(11'd0);
    send(CMD_PUSH, 32'd7);
    send(CMD_POP, 32'h0);

    // capacity dropped below the current count
    set_capacity(11'd3);
    send(CMD_PUSH, 32'd1);
    send(CMD_PUSH, 32'd2);
    send(CMD_PUSH, 32'd3);
    set_capacity(11'd1);
    send(CMD_PUSH, 32'd4);
    send(CMD_POP, 32'h0);
    send(CMD_POP, 32'h0);
    send(CMD_PUSH, 32'd8);
    send(CMD_POP, 32'h0);
    send(CMD_PUSH, 32'd9);

    set_capacity(11'd8);
    run_mix(150, 50);

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_capacity(11'd1);
    run_mix(40, 50);
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    set_capacity(11'd0);
    run_mix(20, 50);

    // long back-pressure with the sender going flat out
    set_capacity(11'd16);
    rx_hold_len = 200;
    tx_idle = 1'b0;
    run_mix(60, 55);
    tx_idle = 1'b1;
    run_mix(100, 50);

    set_capacity(11'd3);
    run_mix(80, 45);

    // capacity above the built depth: fill to DEPTH and overflow
    set_capacity(11'd2047);
    for (k = 0; k < 1030; k++) send(CMD_PUSH, pick_value());
    send(CMD_PEEK, 32'h0);
    send(CMD_MAX, 32'h0);
    set_capacity(11'd1024);
    send(CMD_PUSH, 32'd1);
    send(CMD_POP, 32'h0);
    send(CMD_PUSH, 32'h7FFF_FFFF);
    send(CMD_PUSH, 32'd2);

    set_capacity(11'd5);
    run_mix(30, 40);

    drain();
    repeat (10) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("stack_with_running_max_top: match");
    end else begin
      $display("stack_with_running_max_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/swrm_pkg.sv
src/swrm_ram.sv
src/stack_with_running_max_top.sv
tb/max_stack_checker.sv
tb/tb_top.sv
